FILE: rtl/mics_pkg.sv
// Shared types, constants and codes of the integer core.
package mics_pkg;

    localparam int unsigned REG_COUNT_DEF = 32;
    localparam logic [31:0] RESET_VECTOR_DEF = 32'hbfc00000;
    localparam logic [31:0] ISOLATE_MASK = 32'h00010000;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    localparam logic [2:0] ERR_OK      = 3'd0;
    localparam logic [2:0] ERR_OPCODE  = 3'd1;
    localparam logic [2:0] ERR_OVF     = 3'd2;
    localparam logic [2:0] ERR_DIVZERO = 3'd3;
    localparam logic [2:0] ERR_COP0REG = 3'd4;
    localparam logic [2:0] ERR_COP0WR  = 3'd5;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_WORD  = 2'd1;
    localparam logic [1:0] PEND_SBYTE = 2'd2;
    localparam logic [1:0] PEND_UBYTE = 2'd3;

    // Operation field of an input item.
    localparam logic OPER_EXEC   = 1'b0;
    localparam logic OPER_RETURN = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_DIV,
        ST_DIVFIX,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic        start;
        logic        signed_op;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    typedef struct packed {
        logic [31:0] fetch_address;
        logic [1:0]  mem_op;
        logic [1:0]  mem_size;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic [2:0]  error_code;
    } result_t;

endpackage

FILE: rtl/mics_if.sv
// Valid/ready channel interfaces for input and result items.
interface mics_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] fetched_word;
    logic [31:0] read_data;
    modport source (output valid, operation, fetched_word, read_data, input ready);
    modport sink (input valid, operation, fetched_word, read_data, output ready);
endinterface

interface mics_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] fetch_address;
    logic [1:0]  mem_op;
    logic [1:0]  mem_size;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [2:0]  error_code;
    modport source (output valid, fetch_address, mem_op, mem_size, mem_address,
                    mem_write_data, error_code, input ready);
    modport sink (input valid, fetch_address, mem_op, mem_size, mem_address,
                  mem_write_data, error_code, output ready);
endinterface

FILE: rtl/mics_divider.sv
// Shift-subtract divider, one quotient bit per cycle, with sign handling.
module mics_divider
(
    input  logic                clk,
    input  logic                rst_n,
    input  mics_pkg::div_req_t  req,
    output mics_pkg::div_rsp_t  rsp
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        shifted   = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, dvs_reg};
        if (req.start)
        begin
            negr_next = req.signed_op & req.dividend[31];
            negq_next = req.signed_op & (req.dividend[31] ^ req.divisor[31]);
            quo_next  = (req.signed_op && req.dividend[31]) ? 32'd0 - req.dividend
                                                            : req.dividend;
            dvs_next  = (req.signed_op && req.divisor[31]) ? 32'd0 - req.divisor
                                                           : req.divisor;
            rem_next  = 32'd0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // When the top remainder bit is shifted out, the true value needs 33 bits
            // and is certainly at least the divisor, so the subtraction is taken.
            if (!trial[32] || rem_reg[31])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dvs_reg  <= dvs_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
    end

    always_comb
    begin
        rsp.done      = !busy_reg && (cnt_reg == 6'd32);
        rsp.quotient  = negq_reg ? 32'd0 - quo_reg : quo_reg;
        rsp.remainder = negr_reg ? 32'd0 - rem_reg : rem_reg;
    end

endmodule

FILE: rtl/mics_regfile.sv
// General register file: one read port with registered data, one write port.
module mics_regfile #(
    parameter int unsigned REG_COUNT = mics_pkg::REG_COUNT_DEF
)
(
    input  logic                         clk,
    input  logic [$clog2(REG_COUNT)-1:0] rd_addr,
    output logic [31:0]                  rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(REG_COUNT)-1:0] wr_addr,
    input  logic [31:0]                  wr_data
);

    logic [31:0] mem [REG_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/mips_integer_core_step.sv
// Top level of the integer core: sequencer, architectural state and channels.
// An execute item passes through register file reads, execute, a two-phase writeback
// and the result, and a divide that runs the divider adds its states; a load return goes to the result.
// Throughput: one item at a time; the next item is taken once the result has left.
// Reset clears control state, HI, LO, status and cause and sets the PC to the reset
// vector; after reset a pass clears the register file, and no item is accepted meanwhile.
module mips_integer_core_step #(
    parameter int unsigned REG_COUNT = mics_pkg::REG_COUNT_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    mics_in_if.sink      in_ch,
    mics_out_if.source   out_ch,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    localparam int unsigned AW = $clog2(REG_COUNT);

    mics_pkg::state_t state_reg, state_next;

    logic [31:0] pc_reg, pc_next;
    logic [31:0] held_reg, held_next;
    logic [31:0] ins_reg, ins_next;
    logic [31:0] hi_reg, hi_next, lo_reg, lo_next;
    logic [31:0] status_reg, status_next, cause_reg, cause_next;
    logic [AW-1:0] ptgt_reg, ptgt_next;
    logic [31:0] pval_reg, pval_next;
    logic [1:0]  pkind_reg, pkind_next;
    logic [31:0] a_reg, a_next;
    logic [AW-1:0] wdst_reg, wdst_next;
    logic [31:0] wval_reg, wval_next;
    logic [AW-1:0] optgt_reg, optgt_next;
    logic [31:0] opval_reg, opval_next;
    logic        wphase_reg, wphase_next;
    logic [AW:0] clr_reg, clr_next;
    logic        div_signed_reg, div_signed_next;
    mics_pkg::result_t res_reg, res_next;

    logic [AW-1:0] rf_raddr, rf_waddr;
    logic [31:0]   rf_rdata, rf_wdata;
    logic          rf_we;

    mics_pkg::div_req_t div_req;
    mics_pkg::div_rsp_t div_rsp;

    mics_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
        .clk     (clk),
        .rd_addr (rf_raddr),
        .rd_data (rf_rdata),
        .wr_en   (rf_we),
        .wr_addr (rf_waddr),
        .wr_data (rf_wdata)
    );

    mics_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Instruction fields.
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    logic [31:0] simm, b, ea, pc4, btgt;
    logic [32:0] sum;
    logic        ovf;

    always_comb
    begin
        op   = ins_reg[31:26];
        rs   = ins_reg[25:21];
        rt   = ins_reg[20:16];
        rd   = ins_reg[15:11];
        sh   = ins_reg[10:6];
        fn   = ins_reg[5:0];
        imm  = ins_reg[15:0];
        simm = {{16{imm[15]}}, imm};
        b    = rf_rdata;
        ea   = a_reg + simm;
        pc4  = pc_reg + 32'd4;
        btgt = pc_reg + {simm[29:0], 2'b00};
        sum  = {1'b0, a_reg} + {1'b0, (op == 6'h00) ? b : simm};
        ovf  = (a_reg[31] == ((op == 6'h00) ? b[31] : simm[31])) &&
               (sum[31] != a_reg[31]);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mics_pkg::ST_IDLE:
            begin
                if (clr_reg[AW] && in_ch.valid)
                begin
                    state_next = (in_ch.operation == mics_pkg::OPER_RETURN)
                                 ? mics_pkg::ST_OUT : mics_pkg::ST_READ;
                end
            end
            mics_pkg::ST_READ:
                state_next = mics_pkg::ST_EXEC;
            mics_pkg::ST_EXEC:
            begin
                if (op == 6'h00 && (fn == 6'h1a || fn == 6'h1b) && b != 32'd0 &&
                    !(fn == 6'h1a && a_reg == 32'h80000000 && b == 32'hffffffff))
                begin
                    state_next = mics_pkg::ST_DIV;
                end
                else
                begin
                    state_next = mics_pkg::ST_WRITE;
                end
            end
            mics_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = mics_pkg::ST_DIVFIX;
                end
            end
            mics_pkg::ST_DIVFIX:
                state_next = mics_pkg::ST_WRITE;
            mics_pkg::ST_WRITE:
            begin
                if (wphase_reg)
                begin
                    state_next = mics_pkg::ST_OUT;
                end
            end
            mics_pkg::ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = mics_pkg::ST_IDLE;
                end
            end
            default:
                state_next = mics_pkg::ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        pc_next         = pc_reg;
        held_next       = held_reg;
        ins_next        = ins_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        status_next     = status_reg;
        cause_next      = cause_reg;
        ptgt_next       = ptgt_reg;
        pval_next       = pval_reg;
        pkind_next      = pkind_reg;
        a_next          = a_reg;
        wdst_next       = wdst_reg;
        wval_next       = wval_reg;
        optgt_next      = optgt_reg;
        opval_next      = opval_reg;
        wphase_next     = 1'b0;
        clr_next        = clr_reg;
        div_signed_next = div_signed_reg;
        res_next        = res_reg;
        rf_raddr        = rs;
        rf_waddr        = wdst_reg;
        rf_wdata        = wval_reg;
        rf_we           = 1'b0;
        div_req.start     = 1'b0;
        div_req.signed_op = div_signed_reg;
        div_req.dividend  = a_reg;
        div_req.divisor   = b;
        in_ch.ready     = 1'b0;

        if (!clr_reg[AW])
        begin
            rf_we    = 1'b1;
            rf_waddr = clr_reg[AW-1:0];
            rf_wdata = 32'd0;
            clr_next = clr_reg + {{AW{1'b0}}, 1'b1};
        end

        unique case (state_reg)
            mics_pkg::ST_IDLE:
            begin
                in_ch.ready = clr_reg[AW];
                if (cfg_we)
                begin
                    pc_next = cfg_wdata;
                end
                if (clr_reg[AW] && in_ch.valid)
                begin
                    if (in_ch.operation == mics_pkg::OPER_RETURN)
                    begin
                        unique case (pkind_reg)
                            mics_pkg::PEND_WORD:  pval_next = in_ch.read_data;
                            mics_pkg::PEND_SBYTE:
                                pval_next = {{24{in_ch.read_data[7]}}, in_ch.read_data[7:0]};
                            mics_pkg::PEND_UBYTE:
                                pval_next = {24'd0, in_ch.read_data[7:0]};
                            default: ;
                        endcase
                        pkind_next = mics_pkg::PEND_NONE;
                        res_next = '0;
                        res_next.fetch_address = pc_reg;
                    end
                    else
                    begin
                        ins_next   = held_reg;
                        held_next  = in_ch.fetched_word;
                        rf_raddr   = held_reg[25:21];
                        optgt_next = ptgt_reg;
                        opval_next = pval_reg;
                        ptgt_next  = '0;
                        pval_next  = 32'd0;
                        pkind_next = mics_pkg::PEND_NONE;
                    end
                end
            end
            mics_pkg::ST_READ:
            begin
                a_next   = rf_rdata;
                rf_raddr = rt;
            end
            mics_pkg::ST_EXEC:
            begin
                res_next = '0;
                wdst_next = '0;
                wval_next = 32'd0;
                div_signed_next = (fn == 6'h1a);
                div_req.signed_op = (fn == 6'h1a);
                case (op)
                    6'h00:
                    begin
                        res_next.fetch_address = pc4;
                        case (fn)
                            6'h00: begin wdst_next = rd; wval_next = b << sh; end
                            6'h02: begin wdst_next = rd; wval_next = b >> sh; end
                            6'h03: begin wdst_next = rd; wval_next = $signed(b) >>> sh; end
                            6'h08: res_next.fetch_address = a_reg;
                            6'h09:
                            begin
                                wdst_next = rd;
                                wval_next = pc4;
                                res_next.fetch_address = a_reg;
                            end
                            6'h10: begin wdst_next = rd; wval_next = hi_reg; end
                            6'h12: begin wdst_next = rd; wval_next = lo_reg; end
                            6'h1a, 6'h1b:
                            begin
                                if (b == 32'd0)
                                begin
                                    lo_next = (fn == 6'h1a && a_reg[31]) ? 32'd1
                                                                          : 32'hffffffff;
                                    hi_next = a_reg;
                                    res_next.error_code = mics_pkg::ERR_DIVZERO;
                                end
                                else if (fn == 6'h1a && a_reg == 32'h80000000 &&
                                         b == 32'hffffffff)
                                begin
                                    lo_next = 32'h80000000;
                                    hi_next = 32'd0;
                                end
                                else
                                begin
                                    div_req.start = 1'b1;
                                end
                            end
                            6'h20:
                            begin
                                if (ovf)
                                begin
                                    res_next.error_code = mics_pkg::ERR_OVF;
                                end
                                else
                                begin
                                    wdst_next = rd;
                                    wval_next = sum[31:0];
                                end
                            end
                            6'h21: begin wdst_next = rd; wval_next = sum[31:0]; end
                            6'h23: begin wdst_next = rd; wval_next = a_reg - b; end
                            6'h24: begin wdst_next = rd; wval_next = a_reg & b; end
                            6'h25: begin wdst_next = rd; wval_next = a_reg | b; end
                            6'h2a:
                            begin
                                wdst_next = rd;
                                wval_next = {31'd0, $signed(a_reg) < $signed(b)};
                            end
                            6'h2b: begin wdst_next = rd; wval_next = {31'd0, a_reg < b}; end
                            default: res_next.error_code = mics_pkg::ERR_OPCODE;
                        endcase
                    end
                    6'h01:
                    begin
                        res_next.fetch_address = pc4;
                        if (ins_reg[20])
                        begin
                            wdst_next = 5'd31;
                            wval_next = pc4;
                        end
                        if (ins_reg[16] ? !a_reg[31] : a_reg[31])
                        begin
                            res_next.fetch_address = btgt;
                        end
                    end
                    6'h02, 6'h03:
                    begin
                        if (op == 6'h03)
                        begin
                            wdst_next = 5'd31;
                            wval_next = pc4;
                        end
                        res_next.fetch_address = {pc4[31:28], ins_reg[25:0], 2'b00};
                    end
                    6'h04, 6'h05, 6'h06, 6'h07:
                    begin
                        res_next.fetch_address = pc4;
                        if ((op == 6'h04 && a_reg == b) || (op == 6'h05 && a_reg != b) ||
                            (op == 6'h06 && $signed(a_reg) <= 0) ||
                            (op == 6'h07 && $signed(a_reg) > 0))
                        begin
                            res_next.fetch_address = btgt;
                        end
                    end
                    6'h08:
                    begin
                        res_next.fetch_address = pc4;
                        if (ovf)
                        begin
                            res_next.error_code = mics_pkg::ERR_OVF;
                        end
                        else
                        begin
                            wdst_next = rt;
                            wval_next = sum[31:0];
                        end
                    end
                    6'h09: begin res_next.fetch_address = pc4; wdst_next = rt; wval_next = ea; end
                    6'h0a:
                    begin
                        res_next.fetch_address = pc4;
                        wdst_next = rt;
                        wval_next = {31'd0, $signed(a_reg) < $signed(simm)};
                    end
                    6'h0b:
                    begin
                        res_next.fetch_address = pc4;
                        wdst_next = rt;
                        wval_next = {31'd0, a_reg < simm};
                    end
                    6'h0c:
                    begin
                        res_next.fetch_address = pc4;
                        wdst_next = rt;
                        wval_next = a_reg & {16'd0, imm};
                    end
                    6'h0d:
                    begin
                        res_next.fetch_address = pc4;
                        wdst_next = rt;
                        wval_next = a_reg | {16'd0, imm};
                    end
                    6'h0f:
                    begin
                        res_next.fetch_address = pc4;
                        wdst_next = rt;
                        wval_next = {imm, 16'd0};
                    end
                    6'h10:
                    begin
                        res_next.fetch_address = pc4;
                        if (rs == 5'd4)
                        begin
                            if (rd == 5'd12)
                            begin
                                status_next = b;
                            end
                            else if (rd == 5'd13)
                            begin
                                cause_next = b;
                                if (b != 32'd0)
                                begin
                                    res_next.error_code = mics_pkg::ERR_COP0WR;
                                end
                            end
                            else if (rd == 5'd3 || rd == 5'd5 || rd == 5'd6 ||
                                     rd == 5'd7 || rd == 5'd9 || rd == 5'd11)
                            begin
                                if (b != 32'd0)
                                begin
                                    res_next.error_code = mics_pkg::ERR_COP0WR;
                                end
                            end
                            else
                            begin
                                res_next.error_code = mics_pkg::ERR_COP0REG;
                            end
                        end
                        else if (rs == 5'd0)
                        begin
                            if (rd == 5'd12)
                            begin
                                ptgt_next = rt;
                                pval_next = status_reg;
                            end
                            else if (rd == 5'd13)
                            begin
                                ptgt_next = rt;
                                pval_next = cause_reg;
                            end
                            else
                            begin
                                res_next.error_code = mics_pkg::ERR_COP0REG;
                            end
                        end
                        else
                        begin
                            res_next.error_code = mics_pkg::ERR_OPCODE;
                        end
                    end
                    6'h11, 6'h12, 6'h13: res_next.fetch_address = pc4;
                    6'h20, 6'h23, 6'h24:
                    begin
                        res_next.fetch_address = pc4;
                        ptgt_next = rt;
                        pval_next = 32'd0;
                        pkind_next = (op == 6'h23) ? mics_pkg::PEND_WORD :
                                     ((op == 6'h20) ? mics_pkg::PEND_SBYTE
                                                    : mics_pkg::PEND_UBYTE);
                        res_next.mem_op = mics_pkg::MEM_READ;
                        res_next.mem_size = (op == 6'h23) ? mics_pkg::SIZE_WORD
                                                          : mics_pkg::SIZE_BYTE;
                        res_next.mem_address = ea;
                    end
                    6'h28, 6'h29, 6'h2b:
                    begin
                        res_next.fetch_address = pc4;
                        if ((status_reg & mics_pkg::ISOLATE_MASK) == 32'd0)
                        begin
                            res_next.mem_op = mics_pkg::MEM_WRITE;
                            res_next.mem_address = ea;
                            if (op == 6'h28)
                            begin
                                res_next.mem_size = mics_pkg::SIZE_BYTE;
                                res_next.mem_write_data = {24'd0, b[7:0]};
                            end
                            else if (op == 6'h29)
                            begin
                                res_next.mem_size = mics_pkg::SIZE_HALF;
                                res_next.mem_write_data = {16'd0, b[15:0]};
                            end
                            else
                            begin
                                res_next.mem_size = mics_pkg::SIZE_WORD;
                                res_next.mem_write_data = b;
                            end
                        end
                    end
                    default:
                    begin
                        res_next.fetch_address = pc4;
                        res_next.error_code = mics_pkg::ERR_OPCODE;
                    end
                endcase
                pc_next = res_next.fetch_address;
            end
            mics_pkg::ST_DIV: ;
            mics_pkg::ST_DIVFIX:
            begin
                lo_next = div_rsp.quotient;
                hi_next = div_rsp.remainder;
            end
            mics_pkg::ST_WRITE:
            begin
                // Load value lands first, then the instruction's own write wins.
                wphase_next = 1'b1;
                rf_we = 1'b1;
                if (!wphase_reg)
                begin
                    rf_waddr = optgt_reg;
                    rf_wdata = (optgt_reg == '0) ? 32'd0 : opval_reg;
                end
                else
                begin
                    rf_waddr = wdst_reg;
                    rf_wdata = (wdst_reg == '0) ? 32'd0 : wval_reg;
                end
            end
            mics_pkg::ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mics_pkg::ST_IDLE;
            pc_reg         <= mics_pkg::RESET_VECTOR_DEF;
            held_reg       <= 32'd0;
            hi_reg         <= 32'd0;
            lo_reg         <= 32'd0;
            status_reg     <= 32'd0;
            cause_reg      <= 32'd0;
            ptgt_reg       <= '0;
            pval_reg       <= 32'd0;
            pkind_reg      <= mics_pkg::PEND_NONE;
            wphase_reg     <= 1'b0;
            clr_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            pc_reg         <= pc_next;
            held_reg       <= held_next;
            hi_reg         <= hi_next;
            lo_reg         <= lo_next;
            status_reg     <= status_next;
            cause_reg      <= cause_next;
            ptgt_reg       <= ptgt_next;
            pval_reg       <= pval_next;
            pkind_reg      <= pkind_next;
            wphase_reg     <= wphase_next;
            clr_reg        <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg        <= ins_next;
        a_reg          <= a_next;
        wdst_reg       <= wdst_next;
        wval_reg       <= wval_next;
        optgt_reg      <= optgt_next;
        opval_reg      <= opval_next;
        div_signed_reg <= div_signed_next;
        res_reg        <= res_next;
    end

    always_comb
    begin
        out_ch.valid          = (state_reg == mics_pkg::ST_OUT);
        out_ch.fetch_address  = res_reg.fetch_address;
        out_ch.mem_op         = res_reg.mem_op;
        out_ch.mem_size       = res_reg.mem_size;
        out_ch.mem_address    = res_reg.mem_address;
        out_ch.mem_write_data = res_reg.mem_write_data;
        out_ch.error_code     = res_reg.error_code;
    end

endmodule
